@@ sv/pwca_pkg.sv @@
// Shared types and constants for the PID controller with clamp and anti-windup.
// Used by pwca_regs, pwca_core and pid_with_clamp_antiwindup; no dependencies.
package pwca_pkg;

  localparam int unsigned SampleWidth = 16;
  localparam int unsigned GainWidth   = 24;
  localparam int unsigned ErrWidth    = 17;
  localparam int unsigned DiffWidth   = 18;
  localparam int unsigned AccWidth    = 32;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDatWidth = 24;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_KP = 3'd0,
    REG_KI = 3'd1,
    REG_KD = 3'd2,
    REG_UB = 3'd3,
    REG_LB = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic signed [GainWidth-1:0]   kp;
    logic signed [GainWidth-1:0]   ki;
    logic signed [GainWidth-1:0]   kd;
    logic signed [SampleWidth-1:0] ub;
    logic signed [SampleWidth-1:0] lb;
  } cfg_t;

  localparam logic signed [GainWidth-1:0]   KpReset = 24'sd655;
  localparam logic signed [GainWidth-1:0]   KiReset = 24'sd66;
  localparam logic signed [GainWidth-1:0]   KdReset = 24'sd0;
  localparam logic signed [SampleWidth-1:0] UbReset = 16'sd4096;
  localparam logic signed [SampleWidth-1:0] LbReset = -16'sd4096;

endpackage

@@ sv/pwca_regs.sv @@
// Configuration register file: gains and clamp limits.
// Depends on pwca_pkg for the register indexes and the cfg_t bundle.
module pwca_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pwca_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [pwca_pkg::CfgDatWidth-1:0]    cfg_data,
  output pwca_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp <= pwca_pkg::KpReset;
      cfg.ki <= pwca_pkg::KiReset;
      cfg.kd <= pwca_pkg::KdReset;
      cfg.ub <= pwca_pkg::UbReset;
      cfg.lb <= pwca_pkg::LbReset;
    end else if (cfg_write) begin
      case (cfg_index)
        pwca_pkg::REG_KP: cfg.kp <= cfg_data;
        pwca_pkg::REG_KI: cfg.ki <= cfg_data;
        pwca_pkg::REG_KD: cfg.kd <= cfg_data;
        pwca_pkg::REG_UB: cfg.ub <= cfg_data[pwca_pkg::SampleWidth-1:0];
        pwca_pkg::REG_LB: cfg.lb <= cfg_data[pwca_pkg::SampleWidth-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

endmodule

@@ sv/pwca_core.sv @@
// PID datapath: error, three gain products, rounding, clamp and the
// conditionally updated integrator and last-error state. Depends on pwca_pkg.
module pwca_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pwca_pkg::cfg_t                         cfg,
  input  logic signed [pwca_pkg::SampleWidth-1:0] target,
  input  logic signed [pwca_pkg::SampleWidth-1:0] sensed,
  input  logic                                   advance,
  output logic signed [pwca_pkg::SampleWidth-1:0] drive,
  output logic                                   clamped
);

  localparam int unsigned RawWidth = 58;
  localparam int unsigned ValWidth = RawWidth - 16;

  logic signed [pwca_pkg::AccWidth-1:0] acc;
  logic signed [pwca_pkg::AccWidth-1:0] acc_next;
  logic signed [pwca_pkg::ErrWidth-1:0] prev;

  logic signed [pwca_pkg::ErrWidth-1:0]  err;
  logic signed [pwca_pkg::DiffWidth-1:0] diff;
  logic signed [40:0]                    p_term;
  logic signed [55:0]                    i_term;
  logic signed [41:0]                    d_term;
  logic signed [RawWidth-1:0]            raw;
  logic signed [ValWidth-1:0]            val;
  logic                                  hit_ub;
  logic                                  hit_lb;
  logic signed [pwca_pkg::AccWidth:0]    sum;

  assign err    = {sensed[15], sensed} - {target[15], target};
  assign diff   = {err[16], err} - {prev[16], prev};
  assign p_term = $signed(cfg.kp) * $signed(err);
  assign i_term = $signed(cfg.ki) * $signed(acc);
  assign d_term = $signed(cfg.kd) * $signed(diff);
  assign raw    = RawWidth'(p_term) + RawWidth'(i_term) + RawWidth'(d_term)
                + RawWidth'(32768);
  // floor of the shift by 16 is the upper slice of the two's complement word
  assign val    = $signed(raw[RawWidth-1:16]);
  assign hit_ub = val >= ValWidth'(cfg.ub);
  assign hit_lb = val <= ValWidth'(cfg.lb);

  always_comb begin
    if (hit_ub) begin
      drive   = cfg.ub;
      clamped = 1'b1;
    end else if (hit_lb) begin
      drive   = cfg.lb;
      clamped = 1'b1;
    end else begin
      drive   = val[pwca_pkg::SampleWidth-1:0];
      clamped = 1'b0;
    end
  end

  // saturate the integrator on signed overflow
  assign sum = {acc[31], acc} + (pwca_pkg::AccWidth+1)'(err);
  always_comb begin
    if (sum[32] != sum[31]) begin
      acc_next = sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      acc_next = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      prev <= '0;
    end else if (advance && !hit_ub && !hit_lb) begin
      acc  <= acc_next;
      prev <= err;
    end
  end

endmodule

@@ sv/pid_with_clamp_antiwindup.sv @@
// Top level of the PID controller with output clamp and conditional integration.
// Instantiates pwca_regs and pwca_core; depends on pwca_pkg.
//
//   port group  | direction | handshake             | payload
//   ------------+-----------+-----------------------+-------------------------
//   input item  | in        | in_valid / in_ready   | target, sensed
//   result item | out       | out_valid / out_ready | drive, clamped
//   config      | in        | cfg_write             | cfg_index, cfg_data
//
// An item is registered on entry and its result lands in the output register
// when the output is free; one item per cycle sustained while the output is
// not stalled. The rate is set by the combinational pass through the gain
// multipliers, which must see the integrator updated by the previous item.
// Synchronous reset restores the register defaults and clears integrator and
// last error. A stalled output holds the input register, and in_ready falls
// only while both registers are full and the output is stalled.
module pid_with_clamp_antiwindup (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [pwca_pkg::SampleWidth-1:0] target,
  input  logic signed [pwca_pkg::SampleWidth-1:0] sensed,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [pwca_pkg::SampleWidth-1:0] drive,
  output logic                                    clamped,
  input  logic                                    cfg_write,
  input  logic [pwca_pkg::CfgIdxWidth-1:0]        cfg_index,
  input  logic [pwca_pkg::CfgDatWidth-1:0]        cfg_data
);

  pwca_pkg::cfg_t cfg;

  logic                                    s1_valid;
  logic signed [pwca_pkg::SampleWidth-1:0] s1_target;
  logic signed [pwca_pkg::SampleWidth-1:0] s1_sensed;
  logic                                    out_free;
  logic                                    advance;
  logic signed [pwca_pkg::SampleWidth-1:0] drive_next;
  logic                                    clamped_next;

  pwca_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwca_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .target  (s1_target),
    .sensed  (s1_sensed),
    .advance (advance),
    .drive   (drive_next),
    .clamped (clamped_next)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_target <= target;
      s1_sensed <= sensed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      drive   <= drive_next;
      clamped <= clamped_next;
    end
  end

endmodule

@@ tb/pid_result_checker.sv @@
// Checker for pid_with_clamp_antiwindup: watches the sample and result channels,
// predicts each drive value and compares it with what the block returns.
// Depends on pwca_pkg for widths and register indexes.
module pid_result_checker (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic                                    in_ready,
  input  logic signed [pwca_pkg::SampleWidth-1:0] target,
  input  logic signed [pwca_pkg::SampleWidth-1:0] sensed,
  input  logic                                    out_valid,
  input  logic                                    out_ready,
  input  logic signed [pwca_pkg::SampleWidth-1:0] drive,
  input  logic                                    clamped,
  input  logic                                    cfg_write,
  input  logic [pwca_pkg::CfgIdxWidth-1:0]        cfg_index,
  input  logic [pwca_pkg::CfgDatWidth-1:0]        cfg_data,
  output int                                      failures,
  output int                                      outstanding,
  output int                                      checked
);

  localparam longint SumMax = (longint'(1) << (pwca_pkg::AccWidth - 1)) - 1;
  localparam longint SumMin = -(longint'(1) << (pwca_pkg::AccWidth - 1));

  typedef struct packed {
    logic signed [pwca_pkg::SampleWidth-1:0] drive;
    logic                                    clamped;
  } drive_result_t;

  logic signed [pwca_pkg::GainWidth-1:0]   kp_gain;
  logic signed [pwca_pkg::GainWidth-1:0]   ki_gain;
  logic signed [pwca_pkg::GainWidth-1:0]   kd_gain;
  logic signed [pwca_pkg::SampleWidth-1:0] hi_limit;
  logic signed [pwca_pkg::SampleWidth-1:0] lo_limit;
  logic signed [pwca_pkg::AccWidth-1:0]    err_sum;
  logic signed [pwca_pkg::ErrWidth-1:0]    last_err;

  drive_result_t expected_drives[$];

  // One controller step; integrator and last error move only when the
  // rounded output stays strictly between the limits.
  function automatic drive_result_t control_step(
      input logic signed [pwca_pkg::SampleWidth-1:0] t,
      input logic signed [pwca_pkg::SampleWidth-1:0] s);
    longint        err;
    longint        raw;
    longint        rounded;
    longint        sum;
    drive_result_t r;
    err = longint'(s) - longint'(t);
    raw = longint'(kp_gain) * err
        + longint'(ki_gain) * longint'(err_sum)
        + longint'(kd_gain) * (err - longint'(last_err));
    rounded = (raw + 64'sd32768) >>> 16;
    if (rounded >= longint'(hi_limit)) begin
      r.drive   = hi_limit;
      r.clamped = 1'b1;
    end else if (rounded <= longint'(lo_limit)) begin
      r.drive   = lo_limit;
      r.clamped = 1'b1;
    end else begin
      sum = longint'(err_sum) + err;
      if (sum > SumMax) sum = SumMax;
      if (sum < SumMin) sum = SumMin;
      err_sum   = pwca_pkg::AccWidth'(sum);
      last_err  = pwca_pkg::ErrWidth'(err);
      r.drive   = pwca_pkg::SampleWidth'(rounded);
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    drive_result_t want;
    int            bad;
    int            seen;
    bad  = 0;
    seen = 0;
    if (rst) begin
      kp_gain  = pwca_pkg::KpReset;
      ki_gain  = pwca_pkg::KiReset;
      kd_gain  = pwca_pkg::KdReset;
      hi_limit = pwca_pkg::UbReset;
      lo_limit = pwca_pkg::LbReset;
      err_sum  = '0;
      last_err = '0;
      expected_drives.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          pwca_pkg::REG_KP: kp_gain = cfg_data;
          pwca_pkg::REG_KI: ki_gain = cfg_data;
          pwca_pkg::REG_KD: kd_gain = cfg_data;
          pwca_pkg::REG_UB: hi_limit = cfg_data[pwca_pkg::SampleWidth-1:0];
          pwca_pkg::REG_LB: lo_limit = cfg_data[pwca_pkg::SampleWidth-1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          $error("result with nothing expected: drive %0d clamped %0b", drive, clamped);
          bad++;
        end else begin
          want = expected_drives.pop_front();
          seen = 1;
          if (drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, drive);
            bad++;
          end
          if (clamped !== want.clamped) begin
            $error("clamped: expected %0b, got %0b", want.clamped, clamped);
            bad++;
          end
        end
      end
      if (in_valid && in_ready) expected_drives.push_back(control_step(target, sensed));
    end
    failures    <= failures + bad;
    checked     <= checked + seen;
    outstanding <= expected_drives.size();
  end

endmodule

@@ tb/tb_pid_with_clamp_antiwindup.sv @@
// Testbench top for pid_with_clamp_antiwindup: drives samples and register writes,
// stalls both channels at random and reports the verdict.
// Depends on pwca_pkg, the block and pid_result_checker.
module tb_pid_with_clamp_antiwindup;

  localparam int StallLimit     = 2000;
  localparam int SettleCycles   = 4;
  localparam int RandomPhases   = 8;
  localparam int ItemsPerPhase  = 65;
  localparam int IntegrateItems = 8;

  logic                                    clk       = 1'b0;
  logic                                    rst       = 1'b1;
  logic                                    in_valid  = 1'b0;
  logic                                    in_ready;
  logic signed [pwca_pkg::SampleWidth-1:0] target    = '0;
  logic signed [pwca_pkg::SampleWidth-1:0] sensed    = '0;
  logic                                    out_valid;
  logic                                    out_ready = 1'b0;
  logic signed [pwca_pkg::SampleWidth-1:0] drive;
  logic                                    clamped;
  logic                                    cfg_write = 1'b0;
  logic [pwca_pkg::CfgIdxWidth-1:0]        cfg_index = '0;
  logic [pwca_pkg::CfgDatWidth-1:0]        cfg_data  = '0;

  int failures;
  int outstanding;
  int checked;
  bit steady         = 1'b0;
  int samples_sent   = 0;
  int settings_used  = 0;
  int idle_cycles    = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  pid_with_clamp_antiwindup u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .target    (target),
    .sensed    (sensed),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .clamped   (clamped),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pid_result_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .target      (target),
    .sensed      (sensed),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .drive       (drive),
    .clamped     (clamped),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_pid_with_clamp_antiwindup failed");
      $finish;
    end
  end

  function automatic logic signed [pwca_pkg::SampleWidth-1:0] corner(input int i);
    case (i)
      0:       return 16'sh8000;
      1:       return -16'sd1;
      2:       return 16'sd0;
      default: return 16'sh7FFF;
    endcase
  endfunction

  function automatic logic [pwca_pkg::CfgDatWidth-1:0] pick_gain();
    int unsigned                      span;
    logic [pwca_pkg::CfgDatWidth-1:0] g;
    if ($urandom_range(7) == 0) return pwca_pkg::CfgDatWidth'($urandom);
    span = $urandom_range(20);
    g = pwca_pkg::CfgDatWidth'($urandom_range(1 << span));
    if ($urandom_range(1) == 1) g = -g;
    return g;
  endfunction

  task automatic send_sample(input logic signed [pwca_pkg::SampleWidth-1:0] t,
                             input logic signed [pwca_pkg::SampleWidth-1:0] s);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target   <= t;
    sensed   <= s;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
  endtask

  // Hold the sender until every expected result is back and the pipe is empty.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [pwca_pkg::CfgIdxWidth-1:0] idx,
                         input logic [pwca_pkg::CfgDatWidth-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic configure(input logic [pwca_pkg::CfgDatWidth-1:0]        kp,
                           input logic [pwca_pkg::CfgDatWidth-1:0]        ki,
                           input logic [pwca_pkg::CfgDatWidth-1:0]        kd,
                           input logic signed [pwca_pkg::SampleWidth-1:0] ub,
                           input logic signed [pwca_pkg::SampleWidth-1:0] lb);
    cfg_put(pwca_pkg::REG_KP, kp);
    cfg_put(pwca_pkg::REG_KI, ki);
    cfg_put(pwca_pkg::REG_KD, kd);
    // upper data bits are don't-care for the bounds
    cfg_put(pwca_pkg::REG_UB, {8'($urandom), ub});
    cfg_put(pwca_pkg::REG_LB, {8'($urandom), lb});
    if ($urandom_range(2) == 0) begin
      cfg_put(pwca_pkg::CfgIdxWidth'($urandom_range((1 << pwca_pkg::CfgIdxWidth) - 1,
                                                    int'(pwca_pkg::REG_LB) + 1)),
              pwca_pkg::CfgDatWidth'($urandom));
    end
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic signed [pwca_pkg::SampleWidth-1:0] t;
    logic signed [pwca_pkg::SampleWidth-1:0] s;
    logic signed [pwca_pkg::SampleWidth-1:0] ub;
    logic signed [pwca_pkg::SampleWidth-1:0] lb;
    int                                      span;
    int                                      delta;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gains and limits: every pair of corner samples
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        send_sample(corner(i), corner(j));
      end
    end
    drain();

    configure(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'sh7FFF, 16'sh8000);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh8000, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    drain();

    // inverted limits, then equal limits
    configure(24'd65536, 24'd0, 24'd0, -16'sd100, 16'sd100);
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sd0, 16'sd1000);
    drain();
    configure(24'd65536, 24'd0, 24'd0, 16'sd50, 16'sd50);
    send_sample(16'sd0, 16'sd50);
    drain();

    // zero gains keep the output at zero, so every error is integrated:
    // push the sum up with the largest errors and back down again
    configure(24'd0, 24'd0, 24'd0, 16'sh7FFF, 16'sh8000);
    repeat (IntegrateItems) send_sample(16'sh8000, 16'sh7FFF);
    repeat (IntegrateItems) send_sample(16'sh7FFF, 16'sh8000);
    drain();
    // a negative unity kp with a tiny integral gain on the leftover sum
    configure(24'hFF0000, 24'd1, 24'd0, 16'sh7FFF, 16'sh8000);
    send_sample(16'sd5, 16'sd0);
    send_sample(16'sd5, 16'sd0);
    send_sample(16'sd0, 16'sd0);
    drain();

    for (int p = 0; p < RandomPhases; p++) begin
      steady <= (p == 3);
      ub = 16'($urandom_range(32767));
      lb = 16'(-int'($urandom_range(32768)));
      case (p)
        0: configure(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'sh7FFF, 16'sh8000);
        1: configure(24'h800000, 24'h800000, 24'h800000, 16'sh7FFF, 16'sh8000);
        2: configure(pick_gain(), pick_gain(), pick_gain(), lb, ub);
        default: configure(pick_gain(), pick_gain(), pick_gain(), ub, lb);
      endcase
      repeat (ItemsPerPhase) begin
        t = 16'($urandom);
        if ($urandom_range(3) == 0) begin
          s = 16'($urandom);
        end else begin
          // mostly small errors so the loop spends time inside the limits
          span  = $urandom_range(12);
          delta = int'($urandom_range(2 << span)) - (1 << span);
          s     = 16'(int'(t) + delta);
        end
        send_sample(t, s);
        if ($urandom_range(39) == 0) drain();
      end
      drain();
    end
    steady <= 1'b0;

    $display("sent %0d samples over %0d register settings, %0d results checked",
             samples_sent, settings_used, checked);
    $display("covered corner samples, inverted and equal limits, zero-gain integration");
    if (failures == 0 && outstanding == 0) begin
      $display("tb_pid_with_clamp_antiwindup passed");
    end else begin
      $display("tb_pid_with_clamp_antiwindup failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/pwca_pkg.sv
sv/pwca_regs.sv
sv/pwca_core.sv
sv/pid_with_clamp_antiwindup.sv
tb/pid_result_checker.sv
tb/tb_pid_with_clamp_antiwindup.sv
